/* rtl/spi_master_byte_shifter_assert.svh */
// ----------------------------------------------------------------------------
// SPI master byte shifter assertion macros
// Shared concurrent assertion forms on clk_i with rst_ni disable.
// ----------------------------------------------------------------------------
`ifndef SPI_MASTER_BYTE_SHIFTER_ASSERT_SVH
`define SPI_MASTER_BYTE_SHIFTER_ASSERT_SVH

// same-cycle implication
`define SMS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SMS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/sms_pkg.sv */
// ----------------------------------------------------------------------------
// SPI master byte shifter package
// Item types, register indexes and constants shared by the shifter files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sms_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned BitCntW = 3;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [ByteW-1:0]   ByteOnes = 8'hFF;
  localparam logic [BitCntW-1:0] LastBit  = 3'd7;

  typedef enum logic [0:0] {
    KIND_START = 1'b0,
    KIND_TICK  = 1'b1
  } kind_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_CLOCK_POLARITY = 2'd0,
    CFG_CLOCK_PHASE    = 2'd1,
    CFG_MSB_FIRST      = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    kind_e            kind;
    logic [ByteW-1:0] tx_byte;
    logic             tx_present;
    logic             last_byte;
    logic             miso_level;
  } in_item_t;

  typedef struct packed {
    logic             sclk;
    logic             mosi;
    logic [ByteW-1:0] rx_byte;
    logic             rx_valid;
    logic             busy_res;
  } out_item_t;

  typedef struct packed {
    cfg_idx_e idx;
    logic     value;
  } cfg_wr_t;

  typedef struct packed {
    logic clock_polarity;
    logic clock_phase;
    logic msb_first;
  } cfg_t;

  // forces the clock level on a polarity write
  typedef struct packed {
    logic en;
    logic level;
  } sclk_set_t;

endpackage

/* rtl/sms_chan_if.sv */
// ----------------------------------------------------------------------------
// SPI master byte shifter channel interface
// Valid/ready channel carrying one payload item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sms_chan_if #(
  parameter type T = logic
);

  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);

endinterface

/* rtl/sms_cfg_regs.sv */
// ----------------------------------------------------------------------------
// SPI master byte shifter configuration registers
// Polarity, phase and bit order; a polarity write also sets the clock level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sms_cfg_regs
  import sms_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  sms_chan_if.sink  cfg_i,
  output cfg_t      cfg_o,
  output sclk_set_t sclk_set_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign cfg_i.ready = 1'b1;
  assign wr_en       = cfg_i.valid & cfg_i.ready;

  always_comb begin
    cfg_d            = cfg_q;
    sclk_set_o.en    = 1'b0;
    sclk_set_o.level = cfg_i.data.value;
    if (wr_en) begin
      unique case (cfg_i.data.idx)
        CFG_CLOCK_POLARITY: begin
          cfg_d.clock_polarity = cfg_i.data.value;
          sclk_set_o.en        = 1'b1;
        end
        CFG_CLOCK_PHASE: cfg_d.clock_phase = cfg_i.data.value;
        CFG_MSB_FIRST:   cfg_d.msb_first   = cfg_i.data.value;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{clock_polarity: 1'b1, clock_phase: 1'b1, msb_first: 1'b1};
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* rtl/sms_core.sv */
// ----------------------------------------------------------------------------
// SPI master byte shifter core
// Shift state and one-item update: start loads a byte, ticks run half-periods.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sms_core
  import sms_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      step_en_i,
  input  in_item_t  item_i,
  input  cfg_t      cfg_i,
  input  sclk_set_t sclk_set_i,
  output out_item_t result_o
);

`include "spi_master_byte_shifter_assert.svh"

  logic               clk_level_q, clk_level_d;
  logic               dout_q, dout_d;
  logic [ByteW-1:0]   tx_sh_q, tx_sh_d;
  logic [ByteW-1:0]   rx_sh_q, rx_sh_d;
  logic [BitCntW-1:0] bit_cnt_q, bit_cnt_d;
  logic               second_half_q, second_half_d;
  logic               shifting_q, shifting_d;
  logic               in_xfer_q, in_xfer_d;
  logic               final_q, final_d;
  logic               rx_valid;
  logic [ByteW-1:0]   rx_byte;

  always_comb begin
    clk_level_d   = clk_level_q;
    dout_d        = dout_q;
    tx_sh_d       = tx_sh_q;
    rx_sh_d       = rx_sh_q;
    bit_cnt_d     = bit_cnt_q;
    second_half_d = second_half_q;
    shifting_d    = shifting_q;
    in_xfer_d     = in_xfer_q;
    final_d       = final_q;
    rx_valid      = 1'b0;
    rx_byte       = '0;
    if (step_en_i) begin
      unique case (item_i.kind)
        KIND_START: begin
          if (!shifting_q) begin
            tx_sh_d       = item_i.tx_present ? item_i.tx_byte : ByteOnes;
            rx_sh_d       = ByteOnes;
            bit_cnt_d     = '0;
            second_half_d = 1'b0;
            shifting_d    = 1'b1;
            final_d       = item_i.last_byte;
            if (!in_xfer_q && cfg_i.clock_phase) begin
              clk_level_d = ~clk_level_q;
            end
            in_xfer_d     = 1'b1;
          end
        end
        KIND_TICK: begin
          if (shifting_q) begin
            if (!second_half_q) begin
              if (cfg_i.msb_first) begin
                dout_d  = tx_sh_q[ByteW-1];
                tx_sh_d = {tx_sh_q[ByteW-2:0], 1'b0};
                rx_sh_d = {rx_sh_q[ByteW-2:0], item_i.miso_level};
              end else begin
                dout_d  = tx_sh_q[0];
                tx_sh_d = {1'b0, tx_sh_q[ByteW-1:1]};
                rx_sh_d = {item_i.miso_level, rx_sh_q[ByteW-1:1]};
              end
              clk_level_d   = ~clk_level_q;
              second_half_d = 1'b1;
            end else begin
              // trailing edge dropped at the end of a phase-1 transfer
              if (!(cfg_i.clock_phase && final_q && (bit_cnt_q == LastBit))) begin
                clk_level_d = ~clk_level_q;
              end
              second_half_d = 1'b0;
              if (bit_cnt_q == LastBit) begin
                rx_valid   = 1'b1;
                rx_byte    = rx_sh_q;
                shifting_d = 1'b0;
                bit_cnt_d  = '0;
                if (final_q) begin
                  in_xfer_d = 1'b0;
                end
              end else begin
                bit_cnt_d = bit_cnt_q + 1'b1;
              end
            end
          end
        end
      endcase
    end
    if (sclk_set_i.en) begin
      clk_level_d = sclk_set_i.level;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clk_level_q   <= 1'b1;
      dout_q        <= 1'b1;
      tx_sh_q       <= ByteOnes;
      rx_sh_q       <= ByteOnes;
      bit_cnt_q     <= '0;
      second_half_q <= 1'b0;
      shifting_q    <= 1'b0;
      in_xfer_q     <= 1'b0;
      final_q       <= 1'b0;
    end else begin
      clk_level_q   <= clk_level_d;
      dout_q        <= dout_d;
      tx_sh_q       <= tx_sh_d;
      rx_sh_q       <= rx_sh_d;
      bit_cnt_q     <= bit_cnt_d;
      second_half_q <= second_half_d;
      shifting_q    <= shifting_d;
      in_xfer_q     <= in_xfer_d;
      final_q       <= final_d;
    end
  end

  assign result_o = '{
    sclk:     clk_level_d,
    mosi:     dout_d,
    rx_byte:  rx_byte,
    rx_valid: rx_valid,
    busy_res: shifting_d
  };

  `SMS_ASSERT_IMPL(a_cnt_only_busy, bit_cnt_q != '0, shifting_q, "bit count set while idle")
  `SMS_ASSERT_IMPL(a_half_only_busy, second_half_q, shifting_q, "second half while idle")
  `SMS_ASSERT_IMPL(a_busy_in_xfer, shifting_q, in_xfer_q, "shifting outside a transfer")

endmodule

/* rtl/spi_master_byte_shifter.sv */
// ----------------------------------------------------------------------------
// SPI master byte shifter
// One start or half-period tick item in, one line-state result item out.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle unless the output stalls. Each item is captured
// in an input register, applied to the shift state and its result is held in
// an output register; a stalled output holds the item in the input register.
// Configuration writes are always ready and take effect on the next item; a
// clock_polarity write also sets the SCLK level at once.
`timescale 1ns / 1ps

module spi_master_byte_shifter
  import sms_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  sms_chan_if.sink   cfg_i,
  sms_chan_if.sink   in_i,
  sms_chan_if.source out_o
);

`include "spi_master_byte_shifter_assert.svh"

  logic      in_valid_q, in_valid_d;
  in_item_t  in_q;
  logic      step;
  out_item_t out_q;
  out_item_t result;
  logic      out_valid_q, out_valid_d;
  cfg_t      cfg;
  sclk_set_t sclk_set;

  sms_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_i),
    .cfg_o      (cfg),
    .sclk_set_o (sclk_set)
  );

  assign step     = in_valid_q & (~out_valid_q | out_o.ready);
  assign in_i.ready = ~in_valid_q | step;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_i.valid && in_i.ready) begin
      in_valid_d = 1'b1;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (step) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      in_q <= in_i.data;
    end
    if (step) begin
      out_q <= result;
    end
  end

  sms_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_en_i  (step),
    .item_i     (in_q),
    .cfg_i      (cfg),
    .sclk_set_i (sclk_set),
    .result_o   (result)
  );

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_q;

  `SMS_ASSERT_IMPL(a_rx_ends_busy, out_valid_q && out_q.rx_valid, !out_q.busy_res, "byte done but busy")
  `SMS_ASSERT_NEXT(a_step_gives_out, step, out_valid_q, "processed item gave no result")
  `SMS_ASSERT_NEXT(a_accept_loads, in_i.valid && in_i.ready, in_valid_q, "accepted item not staged")

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// SPI master byte shifter testbench
// Drives start and tick items with random gaps and output stalls across all
// clock polarity, phase and bit order settings, predicts each line-state
// result in a scoreboard and checks every result field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top
  import sms_pkg::*;
();

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned NumPhases     = 12;
  localparam int unsigned PhaseItems    = 72;
  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 2'd3;

  class shifter_scoreboard;
    out_item_t   expected_q[$];
    int unsigned errors;
    cfg_t        cfg;
    logic        clk_level;
    logic        dout_level;
    logic [ByteW-1:0]   tx_shift;
    logic [ByteW-1:0]   rx_shift;
    logic [BitCntW-1:0] bit_idx;
    logic        late_half;
    logic        active;
    logic        xfer_open;
    logic        closing_byte;

    function void clear();
      cfg          = '{clock_polarity: 1'b1, clock_phase: 1'b1, msb_first: 1'b1};
      clk_level    = 1'b1;
      dout_level   = 1'b1;
      tx_shift     = ByteOnes;
      rx_shift     = ByteOnes;
      bit_idx      = '0;
      late_half    = 1'b0;
      active       = 1'b0;
      xfer_open    = 1'b0;
      closing_byte = 1'b0;
      errors       = 0;
      expected_q.delete();
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void apply_write(cfg_wr_t w);
      case (w.idx)
        CFG_CLOCK_POLARITY: begin
          cfg.clock_polarity = w.value;
          clk_level          = w.value;
        end
        CFG_CLOCK_PHASE: begin
          cfg.clock_phase = w.value;
        end
        CFG_MSB_FIRST: begin
          cfg.msb_first = w.value;
        end
        default: begin
        end
      endcase
    endfunction

    function void note_item(in_item_t it);
      out_item_t r;
      r = '0;
      if (it.kind == KIND_START) begin
        if (!active) begin
          tx_shift     = it.tx_present ? it.tx_byte : ByteOnes;
          rx_shift     = ByteOnes;
          bit_idx      = '0;
          late_half    = 1'b0;
          active       = 1'b1;
          closing_byte = it.last_byte;
          // leading toggle only on the first byte of a transfer
          if (!xfer_open && cfg.clock_phase) clk_level = ~clk_level;
          xfer_open = 1'b1;
        end
      end else if (active) begin
        if (!late_half) begin
          if (cfg.msb_first) begin
            dout_level = tx_shift[ByteW-1];
            tx_shift   = {tx_shift[ByteW-2:0], 1'b0};
            rx_shift   = {rx_shift[ByteW-2:0], it.miso_level};
          end else begin
            dout_level = tx_shift[0];
            tx_shift   = {1'b0, tx_shift[ByteW-1:1]};
            rx_shift   = {it.miso_level, rx_shift[ByteW-1:1]};
          end
          clk_level = ~clk_level;
          late_half = 1'b1;
        end else begin
          if (!(cfg.clock_phase && closing_byte && bit_idx == LastBit)) begin
            clk_level = ~clk_level;
          end
          late_half = 1'b0;
          if (bit_idx == LastBit) begin
            r.rx_valid = 1'b1;
            r.rx_byte  = rx_shift;
            active     = 1'b0;
            bit_idx    = '0;
            if (closing_byte) xfer_open = 1'b0;
          end else begin
            bit_idx = bit_idx + 1'b1;
          end
        end
      end
      r.sclk     = clk_level;
      r.mosi     = dout_level;
      r.busy_res = active;
      expected_q.push_back(r);
    endfunction

    function void field_mismatch(string name, int unsigned exp_v, int unsigned got_v);
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (expected_q.size() == 0) begin
        errors++;
        $display("%0t: result with no item pending, expected none, actual %p", $time, got);
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.sclk !== exp_r.sclk) field_mismatch("sclk", exp_r.sclk, got.sclk);
      if (got.mosi !== exp_r.mosi) field_mismatch("mosi", exp_r.mosi, got.mosi);
      if (got.rx_byte !== exp_r.rx_byte) field_mismatch("rx_byte", exp_r.rx_byte, got.rx_byte);
      if (got.rx_valid !== exp_r.rx_valid) begin
        field_mismatch("rx_valid", exp_r.rx_valid, got.rx_valid);
      end
      if (got.busy_res !== exp_r.busy_res) begin
        field_mismatch("busy_res", exp_r.busy_res, got.busy_res);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  sms_chan_if #(.T(cfg_wr_t))   cfg_if ();
  sms_chan_if #(.T(in_item_t))  in_if ();
  sms_chan_if #(.T(out_item_t)) out_if ();

  spi_master_byte_shifter dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  shifter_scoreboard sb;
  in_item_t          plan[$];
  bit                no_gaps;
  int unsigned       idle_cycles;

  always begin
    clk_i = 1'b0;
    #6;
    clk_i = 1'b1;
    #6;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [ByteW-1:0] pick_byte();
    case ($urandom_range(0, 7))
      0: return 8'h00;
      1: return 8'hFF;
      2: return 8'h80;
      3: return 8'h01;
      default: return ByteW'($urandom());
    endcase
  endfunction

  function automatic in_item_t make_start(logic [ByteW-1:0] b, logic present, logic last);
    in_item_t it;
    it.kind       = KIND_START;
    it.tx_byte    = b;
    it.tx_present = present;
    it.last_byte  = last;
    it.miso_level = 1'($urandom_range(0, 1));
    return it;
  endfunction

  function automatic in_item_t make_tick(logic miso);
    in_item_t it;
    it.kind       = KIND_TICK;
    it.tx_byte    = ByteW'($urandom());
    it.tx_present = 1'($urandom_range(0, 1));
    it.last_byte  = 1'($urandom_range(0, 1));
    it.miso_level = miso;
    return it;
  endfunction

  function automatic void plan_phase(int unsigned target);
    int unsigned r;
    in_item_t    noise;
    while (plan.size() < target) begin
      r = $urandom_range(0, 99);
      if (r < 90) begin
        plan.push_back(make_start(pick_byte(), $urandom_range(0, 9) != 0,
                                  $urandom_range(0, 2) == 0));
        // most bytes run to completion, some are cut short
        repeat ((r < 78) ? 16 : $urandom_range(0, 15)) begin
          plan.push_back(make_tick(1'($urandom_range(0, 1))));
        end
      end else begin
        noise      = make_tick(1'($urandom_range(0, 1)));
        noise.kind = kind_e'($urandom_range(0, 1));
        plan.push_back(noise);
      end
    end
    while (plan.size() > target) void'(plan.pop_back());
  endfunction

  task automatic send_item(input in_item_t it);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_item(it);
  endtask

  task automatic drive_plan();
    while (plan.size() > 0) send_item(plan.pop_front());
    in_if.valid <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic v);
    cfg_wr_t w;
    w.idx   = idx;
    w.value = v;
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= w;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    sb.apply_write(w);
  endtask

  // output side stalls
  initial begin
    int unsigned stall;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = pick_gap();
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) sb.check_result(out_if.data);
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)
        || (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [2:0] mode;
    sb = new;
    sb.clear();
    no_gaps      = 1'b0;
    idle_cycles  = 0;
    rst_ni       <= 1'b0;
    in_if.valid  <= 1'b0;
    in_if.data   <= '0;
    cfg_if.valid <= 1'b0;
    cfg_if.data  <= '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: tick while idle, absent byte, start while busy,
    // tick between bytes, second byte of a transfer
    plan.push_back(make_tick(1'b1));
    plan.push_back(make_start(8'h00, 1'b0, 1'b0));
    plan.push_back(make_start(8'h00, 1'b1, 1'b1));
    for (int i = 0; i < 16; i++) plan.push_back(make_tick(i % 3 == 0));
    plan.push_back(make_tick(1'b0));
    plan.push_back(make_start(8'h80, 1'b1, 1'b1));
    for (int i = 0; i < 16; i++) plan.push_back(make_tick(i % 2 == 0));
    drive_plan();

    for (int p = 0; p < NumPhases; p++) begin
      wait_drained();
      mode = (p < 8) ? p[2:0] : 3'($urandom_range(0, 7));
      write_reg(CFG_CLOCK_POLARITY, mode[0]);
      write_reg(CFG_CLOCK_PHASE, mode[1]);
      write_reg(CFG_MSB_FIRST, mode[2]);
      if (p % 3 == 0) write_reg(cfg_idx_e'(CfgIdxUnused), 1'($urandom_range(0, 1)));
      cfg_if.valid <= 1'b0;
      no_gaps = ($urandom_range(0, 3) == 0);
      plan_phase(PhaseItems);
      drive_plan();
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
